@@ src/fixed_point_alu_unit_macros.svh @@
// assertion macros for the fixed-point alu
`ifndef FIXED_POINT_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_ALU_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define FPA_ASSERT_CLK(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("fixed point alu check failed");
`define FPA_ASSERT(lbl, prop) `FPA_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define FPA_ASSERT_CLK(lbl, clk_s, rstn_s, prop)
`define FPA_ASSERT(lbl, prop)
`endif

`endif

@@ src/fpa_pkg.sv @@
package fpa_pkg;

  localparam int OPERATION_BITS = 4;
  localparam int FIELD_BITS     = 32;

  typedef enum logic [OPERATION_BITS-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } fpa_op_t;

endpackage

@@ src/fpa_if.sv @@
interface fpa_in_if import fpa_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [OPERATION_BITS-1:0]    operation;
  logic signed [FIELD_BITS-1:0] operand_a;
  logic signed [FIELD_BITS-1:0] operand_b;

  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if import fpa_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] result_value;
  logic                         compare_true;
  logic                         divide_by_zero;

  modport source (output valid, result_value, compare_true, divide_by_zero, input ready);
  modport sink (input valid, result_value, compare_true, divide_by_zero, output ready);
endinterface

@@ src/fixed_point_alu_unit.sv @@
// channel   dir   handshake        payload
// in_ch     in    valid / ready    operation, operand_a, operand_b
// out_ch    out   valid / ready    result_value, compare_true, divide_by_zero
//
// one item per cycle while out_ch is not stalled; every item passes through the input
// stage, the one-bit-per-stage divider pipeline (beside a delay line) and the output register
// synchronous active-low reset clears all valid bits
// a stall at out_ch freezes every stage at once; in_ch.ready is low only then
module fixed_point_alu_unit import fpa_pkg::*; #(
  parameter int FRACTION_BITS = 8,
  parameter int WORD_BITS     = 32
) (
  input logic   clk,
  input logic   rst_n,
  fpa_in_if.sink    in_ch,
  fpa_out_if.source out_ch
);

`include "fixed_point_alu_unit_macros.svh"

  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int N  = W + F;
  localparam int PW = OPERATION_BITS + W + 2 * W + 3;

  typedef struct packed {
    fpa_op_t                op;
    logic signed [W-1:0]    simple;
    logic signed [2*W-1:0]  prod;
    logic                   neg;
    logic                   dz;
    logic                   cmp;
  } fpa_carry_t;

  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // input stage
  logic                s1_valid_r;
  fpa_op_t             s1_op_r;
  logic signed [W-1:0] s1_a_r;
  logic signed [W-1:0] s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r <= fpa_op_t'(in_ch.operation);
      s1_a_r  <= in_ch.operand_a[W-1:0];
      s1_b_r  <= in_ch.operand_b[W-1:0];
    end
  end

  fpa_carry_t   c_in;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [N-1:0] dividend;

  always_comb begin
    c_in        = '0;
    c_in.op     = s1_op_r;
    c_in.prod   = s1_a_r * s1_b_r;
    c_in.neg    = s1_a_r[W-1] ^ s1_b_r[W-1];
    c_in.dz     = (s1_op_r == OP_DIV) && (s1_b_r == '0);
    mag_a       = s1_a_r[W-1] ? W'(-s1_a_r) : s1_a_r;
    mag_b       = s1_b_r[W-1] ? W'(-s1_b_r) : s1_b_r;
    dividend    = N'(mag_a) << F;
    unique case (s1_op_r) inside
      OP_ADD:      c_in.simple = s1_a_r + s1_b_r;
      OP_SUB:      c_in.simple = s1_a_r - s1_b_r;
      OP_GT:       c_in.cmp = s1_a_r > s1_b_r;
      OP_LT:       c_in.cmp = s1_a_r < s1_b_r;
      OP_GE:       c_in.cmp = s1_a_r >= s1_b_r;
      OP_LE:       c_in.cmp = s1_a_r <= s1_b_r;
      OP_EQ:       c_in.cmp = s1_a_r == s1_b_r;
      OP_NE:       c_in.cmp = s1_a_r != s1_b_r;
      OP_MIN:      c_in.simple = (s1_a_r < s1_b_r) ? s1_a_r : s1_b_r;
      OP_MAX:      c_in.simple = (s1_a_r > s1_b_r) ? s1_a_r : s1_b_r;
      OP_INC:      c_in.simple = s1_a_r + W'(1);
      OP_DEC:      c_in.simple = s1_a_r - W'(1);
      OP_FROM_INT: c_in.simple = s1_a_r <<< F;
      OP_TO_INT:   c_in.simple = s1_a_r >>> F;
      OP_MUL, OP_DIV: c_in.simple = '0;
      default:     c_in.simple = '0;
    endcase
  end

  logic         d_valid;
  logic [PW-1:0] d_data;
  fpa_carry_t   c_out;
  logic [N-1:0] quotient;

  fpa_delay #(.WIDTH(PW), .DEPTH(N)) u_delay (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (s1_valid_r),
    .data_in   (c_in),
    .valid_out (d_valid),
    .data_out  (d_data)
  );

  fpa_div_pipe #(.N(N), .W(W)) u_div (
    .clk      (clk),
    .en       (en),
    .dividend (dividend),
    .divisor  (mag_b),
    .quotient (quotient)
  );

  assign c_out = fpa_carry_t'(d_data);

  // result select
  logic signed [W-1:0]     res_nxt;
  logic signed [2*W-1:0]   prod_sh;
  logic [W-1:0]            q_lo;

  always_comb begin
    prod_sh = c_out.prod >>> F;
    q_lo    = quotient[W-1:0];
    case (c_out.op)
      OP_MUL:  res_nxt = prod_sh[W-1:0];
      OP_DIV:  res_nxt = c_out.dz ? '0 : (c_out.neg ? W'(-q_lo) : q_lo);
      default: res_nxt = c_out.simple;
    endcase
  end

  logic signed [FIELD_BITS-1:0] result_r;
  logic                         cmp_r;
  logic                         dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= FIELD_BITS'(res_nxt);
      cmp_r    <= c_out.cmp;
      dz_r     <= c_out.dz;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_value   = result_r;
  assign out_ch.compare_true   = cmp_r;
  assign out_ch.divide_by_zero = dz_r;

  `FPA_ASSERT(a_dz_zero, out_valid_r && dz_r |-> result_r == '0)
  `FPA_ASSERT(a_cmp_zero, out_valid_r && cmp_r |-> result_r == '0)
  `FPA_ASSERT(a_flags_excl, out_valid_r |-> !(cmp_r && dz_r))

endmodule

@@ src/fpa_div_pipe.sv @@
module fpa_div_pipe #(
  parameter int N = 40,
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         en,
  input  logic [N-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [N-1:0] quotient
);

  logic [W-1:0] rem_r [N];
  logic [N-1:0] dq_r  [N];
  logic [W-1:0] d_r   [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [W-1:0] rem_prev;
    logic [N-1:0] dq_prev;
    logic [W-1:0] d_prev;
    logic [W:0]   trial;
    logic         ge;
    logic [W-1:0] rem_nxt;
    logic [N-1:0] dq_nxt;

    if (i == 0) begin : g_first
      assign rem_prev = '0;
      assign dq_prev  = dividend;
      assign d_prev   = divisor;
    end else begin : g_next
      assign rem_prev = rem_r[i-1];
      assign dq_prev  = dq_r[i-1];
      assign d_prev   = d_r[i-1];
    end

    always_comb begin
      trial   = {rem_prev, dq_prev[N-1]};
      ge      = trial >= {1'b0, d_prev};
      rem_nxt = ge ? W'(trial - {1'b0, d_prev}) : trial[W-1:0];
      dq_nxt  = {dq_prev[N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        dq_r[i]  <= dq_nxt;
        d_r[i]   <= d_prev;
      end
    end
  end

  assign quotient = dq_r[N-1];

endmodule

@@ src/fpa_delay.sv @@
module fpa_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_in,
  input  logic [WIDTH-1:0] data_in,
  output logic             valid_out,
  output logic [WIDTH-1:0] data_out
);

  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] data_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[DEPTH-2:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r[0] <= data_in;
      for (int i = 1; i < DEPTH; i++) begin
        data_r[i] <= data_r[i-1];
      end
    end
  end

  assign valid_out = valid_r[DEPTH-1];
  assign data_out  = data_r[DEPTH-1];

endmodule
